[rtl/fexp_pkg.sv]
// ----------------------------------------------------------------------------
// fexp_pkg
// Shared constants, special-case codes and a leading-zero helper for the float exp core.
// ----------------------------------------------------------------------------
package fexp_pkg;

  localparam int unsigned FpW      = 32;
  localparam int unsigned Latency  = 26;

  localparam logic [31:0] F_LIMIT  = 32'h42B0_0000;  // 88.0
  localparam logic [31:0] F_HALF   = 32'h3F00_0000;
  localparam logic [31:0] F_NHALF  = 32'hBF00_0000;
  localparam logic [31:0] F_ONE    = 32'h3F80_0000;
  localparam logic [31:0] F_LOG2E  = 32'h3FB8_AA3B;
  localparam logic [31:0] F_C1     = 32'h3F31_7218;
  localparam logic [31:0] F_C2     = 32'h3E75_FDF0;
  localparam logic [31:0] F_C3     = 32'h3D63_5844;
  localparam logic [31:0] F_C4     = 32'h3C1D_839F;
  localparam logic [31:0] F_QNAN   = 32'h7FC0_0000;
  localparam logic [31:0] F_PINF   = 32'h7F80_0000;
  localparam logic [31:0] F_PZERO  = 32'h0000_0000;

  typedef enum logic [1:0] {
    SPC_NONE,
    SPC_NAN,
    SPC_INF,
    SPC_ZERO
  } fexp_spc_e;

  // leading zero count, 48 when the word is zero
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

endpackage

[rtl/fexp_in_if.sv]
// ----------------------------------------------------------------------------
// fexp_in_if
// Operand channel: valid/ready with a single-precision bit pattern.
// ----------------------------------------------------------------------------
interface fexp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_bits;

  modport source (output valid, output x_bits, input ready);
  modport sink   (input valid, input x_bits, output ready);
endinterface

[rtl/fexp_out_if.sv]
// ----------------------------------------------------------------------------
// fexp_out_if
// Result channel: valid/ready with a single-precision bit pattern.
// ----------------------------------------------------------------------------
interface fexp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] exp_bits;

  modport source (output valid, output exp_bits, input ready);
  modport sink   (input valid, input exp_bits, output ready);
endinterface

[rtl/float_exp_polynomial_core.sv]
// ----------------------------------------------------------------------------
// float_exp_polynomial_core
// Streaming single-precision e^x: range reduction plus quartic polynomial.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries x_bits, an IEEE-754 single bit pattern; out_o returns
//   exp_bits, the e^x approximation, in the order the operands arrived.
//   A transfer happens on a rising edge with valid and ready both high.
//   One operand is accepted every cycle while the output is not stalled.
//   The datapath is a chain of three-stage float multipliers and adders
//   (14 units), in fixed slots.
//   The whole pipeline advances together: while the output holds a result
//   that the receiver does not take, all stages freeze and in_i.ready is
//   low; no item is dropped or duplicated. Empty slots carry valid low.
//   Reset clears all valid bits; the pipeline is empty afterward.
//   NaN gives 0x7FC00000, x > 88 gives +inf, x < -88 gives +0, and an
//   exponent that falls to zero or below flushes to +0.
// ----------------------------------------------------------------------------
module float_exp_polynomial_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  fexp_in_if.sink       in_i,
  fexp_out_if.source    out_o
);

  localparam int unsigned Lat = fexp_pkg::Latency;

  logic                 en;
  logic [Lat-1:0]       vld_q;

  fexp_pkg::fexp_spc_e  spc_d;
  fexp_pkg::fexp_spc_e  spc_q [Lat-1];

  logic [31:0] t_s3, u_s6, f_s10;
  logic [31:0] tdl_q [4];
  logic [31:0] fdl_q [6];
  logic [31:0] f2, m1, f3, p1, m2, f4, p2, m3, p3, m4, p4;
  logic [31:0] uadd;

  logic [7:0]  ue;
  logic [7:0]  ush;
  logic [4:0]  ush_c;
  logic [23:0] umag;
  logic [22:0] umask;
  logic signed [7:0] n_d, n_q;
  logic [31:0] fn_d, fn_q;
  logic signed [7:0] ndl_q [18];

  logic signed [9:0] efin;
  logic [31:0] res_d, res_q;

  assign en        = !vld_q[Lat-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_i.valid};
    end
  end

  // special input classes
  always_comb begin
    if (in_i.x_bits[30:23] == 8'hFF && in_i.x_bits[22:0] != 23'd0) begin
      spc_d = fexp_pkg::SPC_NAN;
    end else if (in_i.x_bits[30:0] > fexp_pkg::F_LIMIT[30:0]) begin
      spc_d = in_i.x_bits[31] ? fexp_pkg::SPC_ZERO : fexp_pkg::SPC_INF;
    end else begin
      spc_d = fexp_pkg::SPC_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      spc_q[0] <= spc_d;
      for (int i = 1; i < Lat - 1; i++) spc_q[i] <= spc_q[i-1];
    end
  end

  // t = x * log2(e), u = t +/- 0.5
  fexp_fmul u_mul_t (.clk_i, .en_i(en), .a_i(in_i.x_bits), .b_i(fexp_pkg::F_LOG2E),
                     .z_o(t_s3));

  assign uadd = (t_s3[31] && (|t_s3[30:0])) ? fexp_pkg::F_NHALF : fexp_pkg::F_HALF;

  fexp_fadd u_add_u (.clk_i, .en_i(en), .a_i(t_s3), .b_i(uadd), .z_o(u_s6));

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdl_q[0] <= t_s3;
      for (int i = 1; i < 4; i++) tdl_q[i] <= tdl_q[i-1];
    end
  end

  // n = trunc(u), float(n) by clearing fraction bits
  always_comb begin
    ue    = u_s6[30:23];
    ush   = (ue >= 8'd150) ? 8'd0 : 8'd150 - ue;
    ush_c = ush[4:0];
    umag  = {1'b1, u_s6[22:0]} >> ush_c;
    umask = ~((23'd1 << ush_c) - 23'd1);
    if (ue < 8'd127) begin
      n_d  = 8'sd0;
      fn_d = fexp_pkg::F_PZERO;
    end else begin
      n_d  = u_s6[31] ? -$signed(umag[7:0]) : $signed(umag[7:0]);
      fn_d = {u_s6[31], ue, u_s6[22:0] & umask};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q  <= n_d;
      fn_q <= fn_d;
      ndl_q[0] <= n_q;
      for (int i = 1; i < 18; i++) ndl_q[i] <= ndl_q[i-1];
    end
  end

  // f = t - float(n)
  fexp_fadd u_add_f (.clk_i, .en_i(en), .a_i(tdl_q[3]), .b_i({~fn_q[31], fn_q[30:0]}),
                     .z_o(f_s10));

  always_ff @(posedge clk_i) begin
    if (en) begin
      fdl_q[0] <= f_s10;
      for (int i = 1; i < 6; i++) fdl_q[i] <= fdl_q[i-1];
    end
  end

  // powers and polynomial terms
  fexp_fmul u_mul_f2 (.clk_i, .en_i(en), .a_i(f_s10), .b_i(f_s10), .z_o(f2));
  fexp_fmul u_mul_m1 (.clk_i, .en_i(en), .a_i(f_s10), .b_i(fexp_pkg::F_C1), .z_o(m1));
  fexp_fmul u_mul_f3 (.clk_i, .en_i(en), .a_i(f2), .b_i(fdl_q[2]), .z_o(f3));
  fexp_fadd u_add_p1 (.clk_i, .en_i(en), .a_i(fexp_pkg::F_ONE), .b_i(m1), .z_o(p1));
  fexp_fmul u_mul_m2 (.clk_i, .en_i(en), .a_i(f2), .b_i(fexp_pkg::F_C2), .z_o(m2));
  fexp_fmul u_mul_f4 (.clk_i, .en_i(en), .a_i(f3), .b_i(fdl_q[5]), .z_o(f4));
  fexp_fadd u_add_p2 (.clk_i, .en_i(en), .a_i(p1), .b_i(m2), .z_o(p2));
  fexp_fmul u_mul_m3 (.clk_i, .en_i(en), .a_i(f3), .b_i(fexp_pkg::F_C3), .z_o(m3));
  fexp_fadd u_add_p3 (.clk_i, .en_i(en), .a_i(p2), .b_i(m3), .z_o(p3));
  fexp_fmul u_mul_m4 (.clk_i, .en_i(en), .a_i(f4), .b_i(fexp_pkg::F_C4), .z_o(m4));
  fexp_fadd u_add_p4 (.clk_i, .en_i(en), .a_i(p3), .b_i(m4), .z_o(p4));

  // exponent adjust and special cases
  always_comb begin
    efin = $signed({2'b00, p4[30:23]}) + 10'(ndl_q[17]);
    case (spc_q[Lat-2])
      fexp_pkg::SPC_NAN:  res_d = fexp_pkg::F_QNAN;
      fexp_pkg::SPC_INF:  res_d = fexp_pkg::F_PINF;
      fexp_pkg::SPC_ZERO: res_d = fexp_pkg::F_PZERO;
      default: begin
        if (efin <= 10'sd0) res_d = fexp_pkg::F_PZERO;
        else if (efin >= 10'sd255) res_d = fexp_pkg::F_PINF;
        else res_d = {p4[31], efin[7:0], p4[22:0]};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) res_q <= res_d;
  end

  assign out_o.valid    = vld_q[Lat-1];
  assign out_o.exp_bits = res_q;

`ifndef NO_ASSERTIONS
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input accepted while result stalled");

  a_nan_canonical: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.exp_bits[30:23] == 8'hFF |->
      out_o.exp_bits[22:0] == 23'd0 || out_o.exp_bits == fexp_pkg::F_QNAN)
    else $error("non-canonical NaN result");

  a_result_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !out_o.exp_bits[31])
    else $error("negative exp result");
`endif

endmodule

[rtl/fexp_fmul.sv]
// ----------------------------------------------------------------------------
// fexp_fmul
// Three-stage float32 multiplier, round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
module fexp_fmul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] z_o
);

  logic [7:0]         ea, eb;
  logic [23:0]        ma, mb;
  logic [47:0]        prod_d, prod1_q, prod2_q;
  logic signed [9:0]  ebase_d, ebase_q;
  logic               sgn1_q, sgn2_q;

  logic [5:0]         lz;
  logic signed [7:0]  shift_d, shift_q;
  logic signed [9:0]  expn_d, expn_q;
  logic               zero_d, zero_q;

  logic [7:0]         rsh;
  logic [5:0]         rsh_c;
  logic [95:0]        wide;
  logic [47:0]        sh;
  logic               stk, rnd;
  logic [7:0]         efield;
  logic [30:0]        body;
  logic [31:0]        z_d, z_q;

  // stage 1: mantissa product
  always_comb begin
    ea      = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb      = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    ma      = {|a_i[30:23], a_i[22:0]};
    mb      = {|b_i[30:23], b_i[22:0]};
    prod_d  = ma * mb;
    ebase_d = $signed({2'b00, ea}) + $signed({2'b00, eb}) - 10'sd127;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod1_q <= prod_d;
      ebase_q <= ebase_d;
      sgn1_q  <= a_i[31] ^ b_i[31];
    end
  end

  // stage 2: normalize amount
  always_comb begin
    lz     = fexp_pkg::lzc48(prod1_q);
    zero_d = (prod1_q == 48'd0);
    if (ebase_q < $signed({4'b0000, lz})) begin
      shift_d = ebase_q[7:0];
    end else begin
      shift_d = $signed({2'b00, lz});
    end
    expn_d = ebase_q - 10'(shift_d) + 10'sd1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod2_q <= prod1_q;
      shift_q <= shift_d;
      expn_q  <= expn_d;
      zero_q  <= zero_d;
      sgn2_q  <= sgn1_q;
    end
  end

  // stage 3: shift, round, pack
  always_comb begin
    rsh   = 8'(-shift_q);
    rsh_c = (rsh > 8'd63) ? 6'd63 : rsh[5:0];
    wide  = {prod2_q, 48'd0} >> rsh_c;
    if (shift_q >= 0) begin
      sh  = prod2_q << shift_q[5:0];
      stk = 1'b0;
    end else begin
      sh  = wide[95:48];
      stk = |wide[47:0];
    end
    efield = sh[47] ? expn_q[7:0] : 8'd0;
    body   = {efield, sh[46:24]};
    rnd    = sh[23] & (stk | (|sh[22:0]) | sh[24]);
    if (zero_q) begin
      z_d = {sgn2_q, 31'd0};
    end else if (sh[47] && expn_q >= 10'sd255) begin
      z_d = {sgn2_q, 8'hFF, 23'd0};
    end else begin
      z_d = {sgn2_q, body + 31'(rnd)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) z_q <= z_d;
  end

  assign z_o = z_q;

endmodule

[rtl/fexp_fadd.sv]
// ----------------------------------------------------------------------------
// fexp_fadd
// Three-stage float32 adder, round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
module fexp_fadd (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] z_o
);

  logic [31:0] big, sml;
  logic [7:0]  ebig, esml, dexp;
  logic [4:0]  rsh;
  logic [26:0] bext, sext, al;
  logic [58:0] wide;
  logic        stk;
  logic [27:0] sum_d, sum1_q, sum2_q;
  logic [7:0]  exp1_q;
  logic        sgn1_q, zs1_q, sgn2_q, zs2_q;

  logic [5:0]  lz;
  logic [4:0]  lz1, l_d, l_q;
  logic [8:0]  expn_d, expn_q;
  logic        zero_d, zero_q;

  logic [26:0] nrm;
  logic [7:0]  efield;
  logic [30:0] body;
  logic        rnd;
  logic [31:0] z_d, z_q;

  // stage 1: order, align, add
  always_comb begin
    if (a_i[30:0] >= b_i[30:0]) begin
      big = a_i;
      sml = b_i;
    end else begin
      big = b_i;
      sml = a_i;
    end
    ebig  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    esml  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    dexp  = ebig - esml;
    rsh   = (dexp > 8'd31) ? 5'd31 : dexp[4:0];
    bext  = {|big[30:23], big[22:0], 3'b000};
    sext  = {|sml[30:23], sml[22:0], 3'b000};
    wide  = {sext, 32'd0} >> rsh;
    stk   = |wide[31:0];
    al    = {wide[58:33], wide[32] | stk};
    if (big[31] != sml[31]) begin
      sum_d = {1'b0, bext} - {1'b0, al};
    end else begin
      sum_d = {1'b0, bext} + {1'b0, al};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum1_q <= sum_d;
      exp1_q <= ebig;
      sgn1_q <= big[31];
      zs1_q  <= a_i[31] & b_i[31];
    end
  end

  // stage 2: normalize amount
  always_comb begin
    lz     = fexp_pkg::lzc48({sum1_q, 20'd0});
    zero_d = (sum1_q == 28'd0);
    lz1    = 5'(lz - 6'd1);
    if (sum1_q[27]) begin
      l_d    = 5'd0;
      expn_d = {1'b0, exp1_q} + 9'd1;
    end else begin
      if ({3'b000, lz1} < (exp1_q - 8'd1)) l_d = lz1;
      else l_d = 5'(exp1_q - 8'd1);
      expn_d = {1'b0, exp1_q} - {4'd0, l_d};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum2_q <= sum1_q;
      l_q    <= l_d;
      expn_q <= expn_d;
      zero_q <= zero_d;
      sgn2_q <= sgn1_q;
      zs2_q  <= zs1_q;
    end
  end

  // stage 3: shift, round, pack
  always_comb begin
    if (sum2_q[27]) nrm = {sum2_q[27:2], sum2_q[1] | sum2_q[0]};
    else nrm = sum2_q[26:0] << l_q;
    efield = nrm[26] ? expn_q[7:0] : 8'd0;
    body   = {efield, nrm[25:3]};
    rnd    = nrm[2] & (nrm[1] | nrm[0] | nrm[3]);
    if (zero_q) begin
      z_d = {zs2_q, 31'd0};
    end else if (nrm[26] && expn_q >= 9'd255) begin
      z_d = {sgn2_q, 8'hFF, 23'd0};
    end else begin
      z_d = {sgn2_q, body + 31'(rnd)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) z_q <= z_d;
  end

  assign z_o = z_q;

endmodule
